FILE: hw/rtl/tksi_pkg.sv
`timescale 1ns / 1ps

package tksi_pkg;

  // Field widths of the command and result beats.
  localparam int unsigned SquareW  = 6;
  localparam int unsigned ScoreW   = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned RdIdxW   = 3;
  localparam int unsigned PosW     = 4;
  localparam int unsigned CountOutW = 4;
  localparam int unsigned CapW     = 4;

  localparam logic [CapW-1:0] CapacityReset = CapW'(3);

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } tksi_op_e;

  typedef struct packed {
    tksi_op_e                   opcode;
    logic [SquareW-1:0]         from_square;
    logic [SquareW-1:0]         to_square;
    logic signed [ScoreW-1:0]   score;
    logic [RdIdxW-1:0]          read_index;
  } tksi_item_t;

  typedef struct packed {
    logic                       accepted;
    logic [PosW-1:0]            insert_position;
    logic                       evicted;
    logic [CountOutW-1:0]       entry_count;
    logic                       entry_valid;
    logic [SquareW-1:0]         entry_from;
    logic [SquareW-1:0]         entry_to;
    logic signed [ScoreW-1:0]   entry_score;
  } tksi_result_t;

  // One stored list entry.
  typedef struct packed {
    logic [SquareW-1:0]         from_sq;
    logic [SquareW-1:0]         to_sq;
    logic signed [ScoreW-1:0]   score;
  } tksi_entry_t;

  // Control from the top level to one cell.
  typedef struct packed {
    logic commit;     // the insert is kept, cells update this cycle
    logic occupied;   // this cell holds a live entry
    logic below_new;  // this cell lies below the count after the insert
  } tksi_cell_ctrl_t;

  // Status from one cell.
  typedef struct packed {
    logic gt;    // live entry scoring strictly above the new one
    logic spot;  // the new entry lands in this cell
  } tksi_cell_stat_t;

endpackage

FILE: hw/rtl/tksi_cell.sv
`timescale 1ns / 1ps

module tksi_cell
  import tksi_pkg::*;
(
  input  logic            clk_i,
  input  tksi_entry_t     new_entry_i,
  input  tksi_entry_t     prev_entry_i,
  input  logic            prev_gt_i,
  input  tksi_cell_ctrl_t ctrl_i,
  output tksi_cell_stat_t stat_o,
  output tksi_entry_t     entry_o
);

  tksi_entry_t entry_q, entry_d;
  logic        gt;

  // Sorted order makes the strictly-greater flags a prefix of the chain, so
  // the insert point is the first cell that is not greater while its upstream neighbor is.
  assign gt          = ctrl_i.occupied && (entry_q.score > new_entry_i.score);
  assign stat_o.gt   = gt;
  assign stat_o.spot = prev_gt_i && !gt;
  assign entry_o     = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.commit) begin
      if (stat_o.spot) begin
        entry_d = new_entry_i;
      end else if (!gt && ctrl_i.below_new) begin
        entry_d = prev_entry_i;
      end
    end
  end

  // Payload only; the live range is tracked by the count at the top level.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: hw/rtl/top_k_sorted_insert_core.sv
`timescale 1ns / 1ps
// The result beat is registered; it appears on the cycle after start is taken.
// Throughput: one command beat per cycle; busy stays low, since the whole chain
// of compare-and-shift cells settles an insert, clear or read combinationally.
// Reset: the entry count clears to zero and capacity returns to three; stored
// entries are undefined until written. The receiver cannot stall result beats.

module top_k_sorted_insert_core
  import tksi_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tksi_item_t        item_i,
  input  logic              cfg_we_i,
  input  logic [CapW-1:0]   cfg_wdata_i,
  output logic              result_valid_o,
  output tksi_result_t      result_o
);

  // Count width holds MAX_ENTRIES itself; index width addresses one cell.
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [CapW-1:0] capacity_q;
  logic [CntW-1:0] held_q, held_d;
  logic            valid_q;
  tksi_result_t    result_q, result_d;

  tksi_entry_t     new_entry;
  tksi_entry_t     cell_entry [MAX_ENTRIES];
  tksi_cell_stat_t cell_stat  [MAX_ENTRIES];
  tksi_cell_ctrl_t cell_ctrl  [MAX_ENTRIES];

  logic            fire;
  logic            is_insert;
  logic            full;
  logic            any_spot;
  logic            hit_below;
  logic            keep;
  logic [CntW-1:0] new_count;
  logic [IdxW-1:0] spot_idx;
  int unsigned     cap_eff;

  // The cell chain settles every command combinationally, so the core is never busy.
  assign busy      = 1'b0;
  assign fire      = start && !busy;
  assign is_insert = fire && (item_i.opcode == OP_INSERT);

  assign new_entry.from_sq = item_i.from_square;
  assign new_entry.to_sq   = item_i.to_square;
  assign new_entry.score   = item_i.score;

  // A capacity above the cell count saturates to the cell count. When the
  // capacity has been lowered below the count, the count stays as it is and
  // the list counts as full.
  assign cap_eff   = (int'(capacity_q) > int'(MAX_ENTRIES)) ? MAX_ENTRIES
                                                            : int'(capacity_q);
  assign full      = int'(held_q) >= cap_eff;
  assign new_count = full ? held_q : CntW'(held_q + 1'b1);

  // Gather the insert point from the chain. A spot within the live entries
  // always keeps the new entry; a spot at the tail only does when not full.
  always_comb begin
    any_spot  = 1'b0;
    hit_below = 1'b0;
    spot_idx  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cell_stat[i].spot) begin
        any_spot = 1'b1;
        spot_idx = spot_idx | IdxW'(i);
        if (int'(held_q) > i) begin
          hit_below = 1'b1;
        end
      end
    end
  end

  assign keep = is_insert && any_spot && (!full || hit_below);

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    assign cell_ctrl[g].commit    = keep;
    assign cell_ctrl[g].occupied  = int'(held_q) > g;
    assign cell_ctrl[g].below_new = int'(new_count) > g;

    if (g == 0) begin : g_head
      // The head cell has no upstream entry; the new beat stands in for it.
      tksi_cell u_cell (
        .clk_i        (clk_i),
        .new_entry_i  (new_entry),
        .prev_entry_i (new_entry),
        .prev_gt_i    (1'b1),
        .ctrl_i       (cell_ctrl[g]),
        .stat_o       (cell_stat[g]),
        .entry_o      (cell_entry[g])
      );
    end else begin : g_body
      tksi_cell u_cell (
        .clk_i        (clk_i),
        .new_entry_i  (new_entry),
        .prev_entry_i (cell_entry[g-1]),
        .prev_gt_i    (cell_stat[g-1].gt),
        .ctrl_i       (cell_ctrl[g]),
        .stat_o       (cell_stat[g]),
        .entry_o      (cell_entry[g])
      );
    end
  end

  // Next count and the result beat. Fields that an operation does not use
  // are zero.
  always_comb begin
    held_d   = held_q;
    result_d = '0;
    if (fire) begin
      case (item_i.opcode)
        OP_INSERT: begin
          if (keep) begin
            held_d                   = new_count;
            result_d.accepted        = 1'b1;
            result_d.insert_position = PosW'(spot_idx);
            result_d.evicted         = full;
          end
        end
        OP_CLEAR: begin
          held_d = '0;
        end
        OP_READ: begin
          // Index selects one cell; indexes past the live entries read zero.
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ((int'(item_i.read_index) == i) && (int'(held_q) > i)) begin
              result_d.entry_valid = 1'b1;
              result_d.entry_from  = cell_entry[i].from_sq;
              result_d.entry_to    = cell_entry[i].to_sq;
              result_d.entry_score = cell_entry[i].score;
            end
          end
        end
        default: begin
        end
      endcase
      result_d.entry_count = CountOutW'(held_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
      held_q     <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      held_q  <= held_d;
      valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule
